// ===== design/sef_pkg.sv =====
// ----------------------------------------------------------------------------
// sef_pkg: shared types and constants of the Sobel edge filter
// Field widths, register indexes, the control word from the register block
// and the per-channel gradient magnitude function.
// ----------------------------------------------------------------------------
package sef_pkg;

   // payload field widths
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int OUT_COL_W = 11;
   localparam int OUT_ROW_W = 12;
   localparam int ROW_W     = 12;

   // register widths and limits
   localparam int FW_W       = 12;
   localparam int FH_W       = 13;
   localparam int MIN_DIM    = 3;
   localparam int MAX_HEIGHT = 4096;
   localparam int CLAMP_MAX  = 255;

   // APB register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

   // control word from register block to filter core
   typedef struct packed {
      logic [FW_W-1:0] frame_width;
      logic [FH_W-1:0] frame_height;
      logic            restart;     // any register write: new frame next pixel
   } sef_cfg_type;

   typedef logic [CHAN_W-1:0] chan_type;

   // |gx| + |gy| of one channel, clamped; l = left column, m = middle,
   // r = right; index 0 top, 2 bottom
   function automatic chan_type sobel_mag(input chan_type l0, input chan_type l1,
                                          input chan_type l2, input chan_type m0,
                                          input chan_type m2, input chan_type r0,
                                          input chan_type r1, input chan_type r2);
      logic [9:0]         sum_r;
      logic [9:0]         sum_l;
      logic [9:0]         sum_b;
      logic [9:0]         sum_t;
      logic signed [10:0] gx;
      logic signed [10:0] gy;
      logic [9:0]         ax;
      logic [9:0]         ay;
      logic [10:0]        mag;
      sum_r = 10'(r0) + 10'({r1, 1'b0}) + 10'(r2);
      sum_l = 10'(l0) + 10'({l1, 1'b0}) + 10'(l2);
      sum_b = 10'(l2) + 10'({m2, 1'b0}) + 10'(r2);
      sum_t = 10'(l0) + 10'({m0, 1'b0}) + 10'(r0);
      gx  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
      gy  = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
      ax  = gx[10] ? 10'(-gx) : 10'(gx);
      ay  = gy[10] ? 10'(-gy) : 10'(gy);
      mag = 11'(ax) + 11'(ay);
      return (mag > 11'(CLAMP_MAX)) ? chan_type'(CLAMP_MAX) : mag[CHAN_W-1:0];
   endfunction

endpackage

// ===== design/sef_req_if.sv =====
// ----------------------------------------------------------------------------
// sef_req_if: pixel input channel
// Valid/ready handshake carrying one RGB pixel per word.
// ----------------------------------------------------------------------------
interface sef_req_if
   import sef_pkg::*;
();
   logic     valid;
   logic     ready;
   chan_type in_red;
   chan_type in_green;
   chan_type in_blue;

   modport source (output valid, output in_red, output in_green, output in_blue,
                   input ready);
   modport sink   (input valid, input in_red, input in_green, input in_blue,
                   output ready);
endinterface

// ===== design/sef_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sef_rsp_if: edge result channel
// Valid/ready handshake carrying one gradient magnitude word with position.
// ----------------------------------------------------------------------------
interface sef_rsp_if
   import sef_pkg::*;
();
   logic                 valid;
   logic                 ready;
   chan_type             edge_red;
   chan_type             edge_green;
   chan_type             edge_blue;
   logic [OUT_COL_W-1:0] out_column;
   logic [OUT_ROW_W-1:0] out_row;
   logic                 frame_done;

   modport source (output valid, output edge_red, output edge_green, output edge_blue,
                   output out_column, output out_row, output frame_done,
                   input ready);
   modport sink   (input valid, input edge_red, input edge_green, input edge_blue,
                   input out_column, input out_row, input frame_done,
                   output ready);
endinterface

// ===== design/sef_ram.sv =====
// ----------------------------------------------------------------------------
// sef_ram: generic single-write, single-read synchronous RAM
// Read data is registered and holds while read enable is low.
// ----------------------------------------------------------------------------
module sef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sef_csr.sv =====
// ----------------------------------------------------------------------------
// sef_csr: APB register block
// Holds frame width and height; flags a frame restart on every write.
// ----------------------------------------------------------------------------
module sef_csr
   import sef_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output sef_cfg_type           cfg
);

   logic            wr_stb;
   logic            reg_sel;
   logic [FW_W-1:0] width_ff;
   logic [FH_W-1:0] height_ff;

   assign wr_stb     = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];
   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RST;
         height_ff <= FRAME_HEIGHT_RST;
      end else if (wr_stb) begin
         case (reg_sel)
            REG_FRAME_WIDTH:  width_ff  <= csr_pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_pwdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.frame_width  = width_ff;
   assign cfg.frame_height = height_ff;
   assign cfg.restart      = wr_stb;

endmodule

// ===== design/sef_core.sv =====
// ----------------------------------------------------------------------------
// sef_core: line store pipeline and Sobel kernel
// Stage 0 counts position and reads the line store; stage 1 writes back,
// shifts the 3x3 window and computes; the output register holds the result.
// ----------------------------------------------------------------------------
module sef_core
   import sef_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  sef_cfg_type cfg,
   sef_req_if.sink     req,
   sef_rsp_if.source   rsp
);

   localparam int CW = $clog2(MAX_WIDTH);       // column counter / address
   localparam int WW = $clog2(MAX_WIDTH + 1);   // width in use

   typedef logic [PIX_W-1:0] pix_type;

   // effective frame size
   logic [WW-1:0]   width_used;
   logic [FH_W-1:0] height_used;

   always_comb begin
      if (cfg.frame_width < FW_W'(MIN_DIM)) begin
         width_used = WW'(MIN_DIM);
      end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
         width_used = WW'(MAX_WIDTH);
      end else begin
         width_used = WW'(cfg.frame_width);
      end
      if (cfg.frame_height < FH_W'(MIN_DIM)) begin
         height_used = FH_W'(MIN_DIM);
      end else if (cfg.frame_height > FH_W'(MAX_HEIGHT)) begin
         height_used = FH_W'(MAX_HEIGHT);
      end else begin
         height_used = cfg.frame_height;
      end
   end

   // handshake
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s1_adv;
   logic accept;

   assign s1_adv    = s1_valid_ff & (~rsp_valid_ff | rsp.ready);
   assign req.ready = ~s1_valid_ff | s1_adv;
   assign accept    = req.valid & req.ready;

   // stage 0: position counters
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             col_last;
   logic             row_last;
   logic             emit;
   logic [CW-1:0]    col_m1;

   assign col_last = (WW'(col_ff) >= width_used - WW'(1));
   assign row_last = (FH_W'(row_ff) >= height_used - FH_W'(1));
   assign emit     = (row_ff >= ROW_W'(2)) && (WW'(col_ff) >= WW'(2));
   assign col_m1   = col_ff - CW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // line store: upper half is two rows up, lower half the previous row
   logic                 ram_we;
   logic [2*PIX_W-1:0]   ram_wdata;
   logic [2*PIX_W-1:0]   ram_rdata;
   logic [CW-1:0]        addr_ff;
   pix_type              pix_ff;

   assign ram_we    = s1_adv;
   assign ram_wdata = {ram_rdata[PIX_W-1:0], pix_ff};

   sef_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   // stage 1 tags
   logic                 emit_ff;
   logic [OUT_COL_W-1:0] ocol_ff;
   logic [OUT_ROW_W-1:0] orow_ff;
   logic                 done_ff;

   // window: [0] left column, [1] middle column; each top, mid, bottom
   pix_type win_ff [2][3];
   pix_type cur [3];

   assign cur[0] = ram_rdata[2*PIX_W-1:PIX_W];
   assign cur[1] = ram_rdata[PIX_W-1:0];
   assign cur[2] = pix_ff;

   // kernel, one channel per lane
   chan_type mag [3];

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      localparam int SH = (2 - ch) * CHAN_W;
      assign mag[ch] = sobel_mag(win_ff[0][0][SH +: CHAN_W], win_ff[0][1][SH +: CHAN_W],
                                 win_ff[0][2][SH +: CHAN_W], win_ff[1][0][SH +: CHAN_W],
                                 win_ff[1][2][SH +: CHAN_W], cur[0][SH +: CHAN_W],
                                 cur[1][SH +: CHAN_W], cur[2][SH +: CHAN_W]);
   end

   // output register
   chan_type             red_ff, green_ff, blue_ff;
   logic [OUT_COL_W-1:0] rcol_ff;
   logic [OUT_ROW_W-1:0] rrow_ff;
   logic                 rdone_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= emit_ff;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            for (int t = 0; t < 3; t++) begin
               win_ff[k][t] <= '0;
            end
         end
      end else if (s1_adv) begin
         for (int t = 0; t < 3; t++) begin
            win_ff[0][t] <= win_ff[1][t];
            win_ff[1][t] <= cur[t];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= {req.in_red, req.in_green, req.in_blue};
         addr_ff <= col_ff;
         emit_ff <= emit;
         ocol_ff <= OUT_COL_W'(col_m1);
         orow_ff <= row_ff - ROW_W'(1);
         done_ff <= col_last & row_last;
      end
      if (s1_adv && emit_ff) begin
         red_ff   <= mag[0];
         green_ff <= mag[1];
         blue_ff  <= mag[2];
         rcol_ff  <= ocol_ff;
         rrow_ff  <= orow_ff;
         rdone_ff <= done_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.edge_red   = red_ff;
   assign rsp.edge_green = green_ff;
   assign rsp.edge_blue  = blue_ff;
   assign rsp.out_column = rcol_ff;
   assign rsp.out_row    = rrow_ff;
   assign rsp.frame_done = rdone_ff;

endmodule

// ===== design/sobel_edge_filter_rgb_top.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_filter_rgb_top: 3x3 Sobel edge filter for an RGB pixel stream
// Raster-order pixels in, clamped |gx|+|gy| per channel out for interior
// pixels, with column, row and end-of-frame mark.
//
//   Port    Dir      Handshake        Word
//   req     sink     valid/ready      in_red, in_green, in_blue
//   rsp     source   valid/ready      edge_red/green/blue, out_column,
//                                     out_row, frame_done
//   csr_*   slave    APB, pready = 1  0x0 frame_width, 0x4 frame_height
//
// One pixel per clock sustained while rsp is not stalled; a result is
// presented on rsp once its pixel has passed the stage 1 register (line
// store read at accept) and the output register (kernel result).
// The line store is one memory read and written back once per pixel.
// Synchronous reset clears counters, window and valid flags; line store
// contents are undefined until written. A stalled rsp backs up into req
// through ready; border pixels pass through without a result.
// ----------------------------------------------------------------------------
module sobel_edge_filter_rgb_top
   import sef_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   sef_req_if.sink               req,
   sef_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   sef_cfg_type cfg;

   // register block
   sef_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // filter pipeline
   sef_core #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule
